/* rtl/tmf_pkg.sv */
// Shared types and constants of the transient-reset median filter.
`timescale 1ns / 1ps
package tmf_pkg;

  localparam int WinSize    = 8;
  localparam int SampleBits = 12;
  localparam int IdxW       = $clog2(WinSize);
  localparam int CntW       = $clog2(WinSize + 1);

  localparam logic [SampleBits-1:0] ThresholdReset = SampleBits'(200);

  typedef logic [SampleBits-1:0]              sample_t;
  typedef logic [WinSize-1:0][SampleBits-1:0] window_t;

  // Request to the rank unit: which entry to rank and how many entries count.
  typedef struct packed {
    logic [IdxW-1:0] cand;
    logic [CntW-1:0] count;
  } rank_req_t;

  typedef enum logic [1:0] {
    StIdle,
    StRank,
    StDone
  } tmf_state_e;

endpackage

/* rtl/tmf_rank.sv */
// Rank unit: position of one window entry in the stable ascending order.
`timescale 1ns / 1ps
module tmf_rank (
  input  tmf_pkg::window_t          window_i,
  input  tmf_pkg::rank_req_t        req_i,
  output logic [tmf_pkg::CntW-1:0]  rank_o
);
  import tmf_pkg::*;

  sample_t cand_val;

  assign cand_val = window_i[req_i.cand];

  // Equal values are ordered by index so that every entry gets a distinct rank.
  always_comb begin
    rank_o = '0;
    for (int j = 0; j < WinSize; j++) begin
      if ((CntW'(j) < req_i.count) &&
          ((window_i[j] < cand_val) ||
           ((window_i[j] == cand_val) && (IdxW'(j) < req_i.cand)))) begin
        rank_o = rank_o + CntW'(1);
      end
    end
  end

endmodule

/* rtl/transient_reset_median_filter.sv */
// Top level of the transient-reset median filter.
//
// One 12-bit ADC sample enters per transfer on the input channel (in_valid_i,
// in_stall_o, sample_i); one result leaves per transfer on the output channel
// (out_valid_o, out_stall_i, median_o, flushed_o, valid_count_o).
// In the cycle a sample is taken the window is updated: once the window is
// full, a sample further than the threshold from the last median overwrites
// every entry, otherwise it replaces the oldest one. A single rank unit then
// ranks one entry per cycle against the valid entries, picking up the middle
// values, and the median is then formed and registered once the output register
// is free. The input is stalled from the transfer until the median is formed, so
// a new sample is taken only after the previous one is finished. The result sits
// in an output register; the next sample is taken while it waits, but the next
// result is held back, with the input stalled, until the receiver has taken the
// previous one.
// The threshold is written through cfg_we_i and cfg_wdata_i; the user must write it
// only while idle, as the block itself does not enforce this. Reset clears the window
// to zero, empties it, sets the last median to zero and the threshold to 200.
`timescale 1ns / 1ps
module transient_reset_median_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tmf_pkg::SampleBits-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tmf_pkg::SampleBits-1:0]    sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tmf_pkg::SampleBits-1:0]    median_o,
  output logic                              flushed_o,
  output logic [tmf_pkg::CntW-1:0]          valid_count_o
);
  import tmf_pkg::*;

  tmf_state_e state_q, state_d;

  window_t          window_q;
  logic [IdxW-1:0]  wp_q, wp_d;
  logic             full_q, full_d;
  sample_t          prev_med_q;
  sample_t          thr_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  cand_q;
  logic             flush_q;
  sample_t          lo_q, hi_q;

  logic             out_valid_q;
  sample_t          median_q;
  logic             flushed_q;
  logic [CntW-1:0]  valid_count_q;

  logic             accept;
  logic             rank_step;
  logic             finish;
  logic             last_cand;
  logic             flush;
  sample_t          diff;
  logic [CntW-1:0]  rank;
  logic [CntW-1:0]  mid_hi;
  logic [CntW-1:0]  mid_lo;
  logic [SampleBits:0] mid_sum;
  sample_t          median_d;
  rank_req_t        req;

  assign accept = in_valid_i && !in_stall_o;

  assign diff  = (sample_i >= prev_med_q) ? sample_i - prev_med_q : prev_med_q - sample_i;
  assign flush = full_q && (diff > thr_q);

  always_comb begin
    wp_d   = wp_q;
    full_d = full_q;
    if (!flush) begin
      if (wp_q == IdxW'(WinSize - 1)) begin
        wp_d   = '0;
        full_d = 1'b1;
      end else begin
        wp_d = wp_q + IdxW'(1);
      end
    end
    count_d = full_d ? CntW'(WinSize) : CntW'(wp_d);
  end

  assign req.cand  = cand_q;
  assign req.count = count_q;

  tmf_rank u_rank (
    .window_i (window_q),
    .req_i    (req),
    .rank_o   (rank)
  );

  assign last_cand = (CntW'(cand_q) + CntW'(1)) == count_q;
  assign mid_hi    = count_q >> 1;
  assign mid_lo    = mid_hi - CntW'(1);
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign median_d  = count_q[0] ? hi_q : mid_sum[SampleBits:1];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (accept) state_d = StRank;
      StRank:  if (last_cand) state_d = StDone;
      StDone:  if (!out_valid_q || !out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    rank_step  = 1'b0;
    finish     = 1'b0;
    case (state_q)
      StIdle:  in_stall_o = 1'b0;
      StRank:  rank_step  = 1'b1;
      StDone:  finish     = !out_valid_q || !out_stall_i;
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      window_q    <= '0;
      wp_q        <= '0;
      full_q      <= 1'b0;
      prev_med_q  <= '0;
      thr_q       <= ThresholdReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (accept) begin
        for (int i = 0; i < WinSize; i++) begin
          if (flush || (IdxW'(i) == wp_q)) begin
            window_q[i] <= sample_i;
          end
        end
        wp_q   <= wp_d;
        full_q <= full_d;
      end
      if (finish) begin
        prev_med_q  <= median_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      count_q <= count_d;
      flush_q <= flush;
      cand_q  <= '0;
    end
    if (rank_step) begin
      cand_q <= cand_q + IdxW'(1);
      if (rank == mid_hi) begin
        hi_q <= window_q[cand_q];
      end
      if (rank == mid_lo) begin
        lo_q <= window_q[cand_q];
      end
    end
    if (finish) begin
      median_q      <= median_d;
      flushed_q     <= flush_q;
      valid_count_q <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign median_o      = median_q;
  assign flushed_o     = flushed_q;
  assign valid_count_o = valid_count_q;

endmodule

/* tb/sv/transient_reset_median_filter_tb.sv */
// Self-checking testbench for the transient-reset median filter.
`timescale 1ns / 1ps
module transient_reset_median_filter_tb;
  import tmf_pkg::*;

  localparam int SampleMax     = (1 << SampleBits) - 1;
  localparam int DrainCycles   = 14;
  localparam int HoldOffCycles = 160;
  localparam int WatchdogLimit = 1000;
  localparam int PhaseItems    = 180;

  // Tracks the filter's window and threshold, and holds the medians still owed by the block.
  class median_checker;
    typedef struct {
      sample_t         median;
      logic            flushed;
      logic [CntW-1:0] count;
    } median_result_t;

    sample_t         win [WinSize];
    int              wr_ptr;
    bit              full;
    sample_t         last_median;
    sample_t         threshold;
    median_result_t  due_results [$];
    int              errors;
    int              n_inputs;
    int              n_checked;
    int              n_flushes;

    function new();
      foreach (win[i]) win[i] = '0;
      wr_ptr      = 0;
      full        = 1'b0;
      last_median = '0;
      threshold   = ThresholdReset;
      errors      = 0;
      n_inputs    = 0;
      n_checked   = 0;
      n_flushes   = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      errors++;
    endtask

    // Applies one accepted sample to the window and queues the median it gives.
    function void note_sample(sample_t s);
      median_result_t  r;
      sample_t         ranked [WinSize];
      sample_t         t;
      logic [SampleBits:0] pair;
      int              diff;
      int              cnt;
      int              i;
      int              j;
      bit              flush;
      flush = 1'b0;
      if (full) begin
        diff  = (s >= last_median) ? int'(s) - int'(last_median)
                                   : int'(last_median) - int'(s);
        flush = diff > int'(threshold);
      end
      if (flush) begin
        foreach (win[k]) win[k] = s;
      end else begin
        win[wr_ptr] = s;
        if (wr_ptr == WinSize - 1) begin
          wr_ptr = 0;
          full   = 1'b1;
        end else begin
          wr_ptr++;
        end
      end
      cnt = full ? WinSize : wr_ptr;
      for (i = 0; i < cnt; i++) ranked[i] = win[i];
      for (i = 1; i < cnt; i++) begin
        t = ranked[i];
        j = i;
        while (j > 0 && ranked[j-1] > t) begin
          ranked[j] = ranked[j-1];
          j--;
        end
        ranked[j] = t;
      end
      if (cnt % 2 == 0) begin
        pair     = {1'b0, ranked[cnt/2-1]} + {1'b0, ranked[cnt/2]};
        r.median = pair[SampleBits:1];
      end else begin
        r.median = ranked[cnt/2];
      end
      r.flushed   = flush;
      r.count     = CntW'(cnt);
      last_median = r.median;
      n_inputs++;
      if (flush) n_flushes++;
      due_results.push_back(r);
    endfunction

    task check_result(sample_t median, logic flushed, logic [CntW-1:0] count);
      median_result_t e;
      n_checked++;
      if (due_results.size() == 0) begin
        report($sformatf("median %0d arrived with no sample outstanding", median));
        return;
      end
      e = due_results.pop_front();
      if (median !== e.median)
        report($sformatf("result %0d: median %0d, predicted %0d",
                         n_checked, median, e.median));
      if (flushed !== e.flushed)
        report($sformatf("result %0d: flushed %0b, predicted %0b",
                         n_checked, flushed, e.flushed));
      if (count !== e.count)
        report($sformatf("result %0d: valid_count %0d, predicted %0d",
                         n_checked, count, e.count));
    endtask
  endclass

  logic            clk_i;
  logic            rst_ni       = 1'b0;
  logic            cfg_we_i     = 1'b0;
  sample_t         cfg_wdata_i  = '0;
  logic            in_valid_i   = 1'b0;
  logic            in_stall_o;
  sample_t         sample_i     = '0;
  logic            out_valid_o;
  logic            out_stall_i  = 1'b0;
  sample_t         median_o;
  logic            flushed_o;
  logic [CntW-1:0] valid_count_o;

  median_checker chk = new();
  int            level = 2048;
  int            n_settings = 1;
  int            idle_cycles = 0;
  bit            held_off = 1'b0;

  transient_reset_median_filter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .median_o      (median_o),
    .flushed_o     (flushed_o),
    .valid_count_o (valid_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic sample_t to_sample(int v);
    if (v < 0) return '0;
    if (v > SampleMax) return sample_t'(SampleMax);
    return sample_t'(v);
  endfunction

  // Mostly a noisy level with occasional steps, plus values placed on the flush boundary.
  function automatic sample_t pick_sample();
    int r;
    int amp;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      level = $urandom_range(0, SampleMax);
      return sample_t'(level);
    end
    if (r < 10) return sample_t'($urandom_range(0, SampleMax));
    if (r < 12) return '0;
    if (r < 14) return sample_t'(SampleMax);
    if (r < 24) begin
      if ($urandom_range(0, 1) == 1)
        return to_sample(int'(chk.last_median) + int'(chk.threshold) + $urandom_range(0, 1));
      return to_sample(int'(chk.last_median) - int'(chk.threshold) - $urandom_range(0, 1));
    end
    amp = $urandom_range(0, 400);
    return to_sample(level + $urandom_range(0, 2 * amp) - amp);
  endfunction

  task automatic send_sample(sample_t s);
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
    chk.note_sample(s);
  endtask

  task automatic pause(int cycles);
    in_valid_i <= 1'b0;
    sample_i   <= sample_t'($urandom_range(0, SampleMax));
    repeat (cycles) @(posedge clk_i);
  endtask

  // The threshold only changes once every owed median has left the block.
  task automatic write_threshold(sample_t v);
    in_valid_i <= 1'b0;
    while (chk.due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    chk.threshold  = v;
    n_settings++;
  endtask

  task automatic run_phase(int n, bit no_gaps);
    int sent;
    int len;
    int gap;
    sent = 0;
    while (sent < n) begin
      len = $urandom_range(1, 20);
      if (len > n - sent) len = n - sent;
      repeat (len) send_sample(pick_sample());
      sent += len;
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) pause(gap);
    end
  endtask

  // Stimulus.
  initial begin
    sample_t settings [9];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Filling the window: no transient test until the pointer first wraps.
    send_sample(sample_t'(SampleMax));
    send_sample('0);
    send_sample(sample_t'(SampleMax));
    send_sample('0);
    send_sample(12'd2048);
    send_sample(12'd1);
    send_sample(sample_t'(SampleMax - 1));
    send_sample(12'd2047);
    // A difference equal to the threshold keeps the window; one more flushes it.
    send_sample(to_sample(int'(chk.last_median) + int'(chk.threshold)));
    send_sample(to_sample(int'(chk.last_median) - int'(chk.threshold) - 1));
    send_sample(sample_t'(SampleMax));
    send_sample('0);
    send_sample('0);
    write_threshold('0);
    send_sample(chk.last_median);
    send_sample(to_sample(int'(chk.last_median) + 1));
    send_sample(sample_t'(SampleMax));
    send_sample(sample_t'(SampleMax));
    write_threshold(sample_t'(SampleMax));
    send_sample('0);
    send_sample(sample_t'(SampleMax));
    send_sample('0);
    send_sample(sample_t'(SampleMax));

    settings = '{ThresholdReset, '0, sample_t'(SampleMax), 12'd1,
                 sample_t'(SampleMax - 1), sample_t'($urandom_range(0, 63)),
                 sample_t'($urandom_range(64, 1023)),
                 sample_t'($urandom_range(0, SampleMax)), ThresholdReset};
    foreach (settings[p]) begin
      write_threshold(settings[p]);
      run_phase(PhaseItems, p == 2);
    end

    in_valid_i <= 1'b0;
    while (chk.due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (chk.due_results.size() != 0)
      chk.report("medians still owed at the end of the run");

    $display("Ran %0d samples through %0d threshold settings; %0d medians checked.",
             chk.n_inputs, n_settings, chk.n_checked);
    $display("%0d samples flushed the window.", chk.n_flushes);
    if (chk.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver: the stall behaviour changes between random spans, with one long hold-off.
  initial begin
    int mode;
    int span;
    int cyc;
    cyc = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(40, 250);
      repeat (span) begin
        if (!held_off && chk.n_checked >= 300 && in_valid_i) begin
          held_off = 1'b1;
          out_stall_i <= 1'b1;
          repeat (HoldOffCycles) @(posedge clk_i);
        end
        case (mode)
          0: begin
            out_stall_i <= 1'b0;
          end
          1: begin
            out_stall_i <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_stall_i <= ($urandom_range(0, 4) != 0);
          end
          default: begin
            out_stall_i <= ((cyc % 11) < 4);
          end
        endcase
        cyc++;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      chk.check_result(median_o, flushed_o, valid_count_o);
  end

  // Ends the run if neither channel completes a transfer for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog: no transfer for %0d cycles, %0d medians still owed.",
                 idle_cycles, chk.due_results.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule

/* files.f */
rtl/tmf_pkg.sv
rtl/tmf_rank.sv
rtl/transient_reset_median_filter.sv
tb/sv/transient_reset_median_filter_tb.sv
